// ===== rtl/core/gwm_pkg.sv =====
// ----------------------------------------------------------------------------
// gwm_pkg: shared types and constants for the glob matcher
// request kinds, cell control bundle, result record and case folding
// ----------------------------------------------------------------------------
`default_nettype none

package gwm_pkg;

  // request kinds carried on in_tuser
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_MASK  = 2'd1,
    REQ_SUBJ  = 2'd2,
    REQ_END   = 2'd3
  } req_type_t;

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] ANY_CHAR  = 8'h3F;

  // broadcast from the control logic to every cell
  typedef struct packed {
    logic       restart;    // back to start position only
    logic       step;       // consume one subject byte
    logic       load;       // write mask byte at the tail cell
    logic [7:0] data_byte;  // case-folded mask or subject byte
  } gwm_ctl_t;

  typedef struct packed {
    logic mask_overflow;
    logic matched;
  } gwm_res_t;

  // fold ascii a-z onto A-Z
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wildcard_glob_matcher_core.sv =====
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_core: case-insensitive glob matcher with '*' and '?'
// mask held in a chain of cells; while in_tready is high, one subject byte advanced per cycle
// ----------------------------------------------------------------------------
// an end-of-subject result is registered in the output register, or in the skid slot while out_ stalls
// throughput: one request per cycle of any kind while in_tready is high; every cell
//   updates its active bit in parallel, so only the result buffer holds requests back
// results sit in a two-entry buffer; in_tready falls only while both are full
// reset (rst_n low, synchronous): empty mask, overflow cleared, start active
`default_nettype none

module wildcard_glob_matcher_core import gwm_pkg::*; #(
  parameter int unsigned MASK_LEN = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic [1:0] in_tuser,   // [1:0] req_type
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [0] matched, [1] mask_overflow, rest zero
);

  // length counters must hold MASK_LEN itself
  localparam int unsigned LW = $clog2(MASK_LEN + 1);

  // raw_len counts every byte taken into the mask (for overflow);
  // stored_len counts cells in use after runs of stars are collapsed
  logic [LW-1:0] raw_len_r, raw_len_nxt;
  logic [LW-1:0] stored_len_r, stored_len_nxt;
  logic          last_star_r, last_star_nxt;
  logic          ovf_r, ovf_nxt;
  logic          act_end_r, act_end_nxt;   // position past the last cell

  gwm_ctl_t  ctl;
  req_type_t req;
  logic      in_fire;
  logic      byte_nz;
  logic      is_star_byte;
  logic      res_push;
  gwm_res_t  res;
  gwm_res_t  out_res;
  logic      buf_room;

  logic [MASK_LEN-1:0] adv;
  logic [MASK_LEN-1:0] skip;
  logic [MASK_LEN-1:0] hit;
  logic                hit_end;

  assign in_tready    = buf_room;
  assign in_fire      = in_tvalid & in_tready;
  assign req          = req_type_t'(in_tuser);
  assign byte_nz      = (in_tdata != 8'd0);
  assign is_star_byte = (in_tdata == STAR_CHAR);

  // request decode and mask bookkeeping
  always_comb begin
    ctl            = '0;
    ctl.data_byte  = fold_case(in_tdata);
    raw_len_nxt    = raw_len_r;
    stored_len_nxt = stored_len_r;
    last_star_nxt  = last_star_r;
    ovf_nxt        = ovf_r;
    res_push       = 1'b0;
    if (in_fire) begin
      case (req)
        REQ_CLEAR: begin
          ctl.restart    = 1'b1;
          raw_len_nxt    = '0;
          stored_len_nxt = '0;
          last_star_nxt  = 1'b0;
          ovf_nxt        = 1'b0;
        end
        REQ_MASK: begin
          if (byte_nz) begin
            ctl.restart = 1'b1;
            if (raw_len_r < LW'(MASK_LEN)) begin
              raw_len_nxt = raw_len_r + LW'(1);
              // a star right after a star adds nothing to the language
              if (!(is_star_byte && last_star_r)) begin
                ctl.load       = 1'b1;
                stored_len_nxt = stored_len_r + LW'(1);
                last_star_nxt  = is_star_byte;
              end
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
        REQ_SUBJ: begin
          ctl.step = byte_nz;
        end
        REQ_END: begin
          ctl.restart = 1'b1;
          res_push    = 1'b1;
        end
        default: begin
          ctl = ctl;
        end
      endcase
    end
  end

  // final position sits after the last cell
  assign hit_end = (act_end_r | skip[MASK_LEN-1]) & (stored_len_r == LW'(MASK_LEN));

  always_comb begin
    act_end_nxt = act_end_r;
    if (ctl.restart) begin
      act_end_nxt = 1'b0;
    end else if (ctl.step) begin
      act_end_nxt = adv[MASK_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_len_r    <= '0;
      stored_len_r <= '0;
      last_star_r  <= 1'b0;
      ovf_r        <= 1'b0;
      act_end_r    <= 1'b0;
    end else begin
      raw_len_r    <= raw_len_nxt;
      stored_len_r <= stored_len_nxt;
      last_star_r  <= last_star_nxt;
      ovf_r        <= ovf_nxt;
      act_end_r    <= act_end_nxt;
    end
  end

  // cell chain: each cell hands its advance and star-skip bits to the next
  for (genvar i = 0; i < MASK_LEN; i++) begin : g_cell
    logic adv_in_w;
    logic skip_in_w;
    if (i == 0) begin : g_head
      assign adv_in_w  = 1'b0;
      assign skip_in_w = 1'b0;
    end else begin : g_link
      assign adv_in_w  = adv[i-1];
      assign skip_in_w = skip[i-1];
    end
    gwm_cell #(
      .IDX (i),
      .LW  (LW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .stored_len (stored_len_r),
      .adv_in     (adv_in_w),
      .skip_in    (skip_in_w),
      .adv_out    (adv[i]),
      .skip_out   (skip[i]),
      .hit_out    (hit[i])
    );
  end

  // exactly one position is the end, so an or over the hits selects it
  assign res.matched       = (|hit) | hit_end;
  assign res.mask_overflow = ovf_r;

  gwm_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_push),
    .push_data  (res),
    .can_accept (buf_room),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = {6'd0, out_res.mask_overflow, out_res.matched};

  a_len_order: assert property (@(posedge clk) disable iff (!rst_n)
    stored_len_r <= raw_len_r)
    else $error("collapsed mask longer than raw mask");

  a_clear_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && req == REQ_CLEAR) |=> (!ovf_r && stored_len_r == '0))
    else $error("clear request left mask state behind");

  a_ovf_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> (raw_len_r == LW'(MASK_LEN)))
    else $error("overflow flagged with room left");

  a_end_gone: assert property (@(posedge clk) disable iff (!rst_n)
    (stored_len_r != LW'(MASK_LEN)) |-> !act_end_r)
    else $error("final position active past the mask end");

endmodule

`default_nettype wire

// ===== rtl/core/gwm_cell.sv =====
// ----------------------------------------------------------------------------
// gwm_cell: one mask position of the matcher chain
// holds a folded mask byte and the active bit of its position
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_cell import gwm_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned LW  = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire gwm_ctl_t      ctl,
  input  wire logic [LW-1:0] stored_len,
  input  wire logic          adv_in,    // previous cell matched a byte
  input  wire logic          skip_in,   // previous cell is an active star
  output logic               adv_out,
  output logic               skip_out,
  output logic               hit_out    // this position is the active end
);

  localparam logic [LW-1:0] MY_IDX   = LW'(IDX);
  localparam logic          IS_FIRST = (IDX == 0);

  logic [7:0] char_r;
  logic       act_r;
  logic       act_nxt;
  logic       valid;
  logic       is_end;
  logic       closed;
  logic       is_star;
  logic       is_match;

  assign valid    = (stored_len > MY_IDX);
  assign is_end   = (stored_len == MY_IDX);
  // stars never sit next to each other, so closure is a single hop
  assign closed   = act_r | skip_in;
  assign is_star  = (char_r == STAR_CHAR);
  assign is_match = (char_r == ANY_CHAR) || (char_r == ctl.data_byte);

  assign skip_out = act_r & valid & is_star;
  assign adv_out  = closed & valid & ~is_star & is_match;
  assign hit_out  = closed & is_end;

  always_comb begin
    act_nxt = act_r;
    if (ctl.restart) begin
      act_nxt = IS_FIRST;
    end else if (ctl.step) begin
      act_nxt = adv_in | (closed & valid & is_star);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= IS_FIRST;
    end else begin
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && is_end) begin
      char_r <= ctl.data_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gwm_obuf.sv =====
// ----------------------------------------------------------------------------
// gwm_obuf: two-entry result buffer
// output register plus skid slot so requests keep flowing under backpressure
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_obuf import gwm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire gwm_res_t push_data,
  output logic          can_accept,
  output logic          out_valid,
  input  wire logic     out_ready,
  output gwm_res_t      out_data
);

  logic     out_valid_r, out_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  gwm_res_t out_data_r, out_data_nxt;
  gwm_res_t skid_data_r, skid_data_nxt;
  logic     pop;

  assign pop        = out_valid_r & out_ready;
  assign can_accept = ~skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      // no push can arrive while the skid slot is full
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = push_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = push_data;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot full with empty output register");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result changed");

  a_push_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("result pushed into full buffer");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for wildcard_glob_matcher_core
// streams mask and subject requests, predicts each end-of-subject verdict
// with a cycle-free glob tracker and compares every result in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import gwm_pkg::*;

  localparam int unsigned MASK_LEN = 128;

  // the tracker state below is reset once at start and otherwise written only
  // from accepted requests, so a single checker process owns it after reset

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] data_byte
  logic [1:0] in_tuser = 2'b00;   // [1:0] req_type
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [0] matched, [1] mask_overflow, rest zero

  wildcard_glob_matcher_core #(
    .MASK_LEN(MASK_LEN)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #6 clk = ~clk;

  // glob tracker: mask bytes, live positions 0..len, overflow flag
  logic [7:0]      pat_mem [MASK_LEN];
  int unsigned     pat_len;
  logic [MASK_LEN:0] live;
  logic            pat_dropped;

  gwm_res_t pending_verdicts [$];
  int unsigned fail_count = 0;

  // traffic shaping
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic        rx_hold = 1'b0;
  int unsigned live_reqs = 0;     // requests that change state or give a result

  // scratch buffers for building a mask and a subject that fits it
  logic [7:0] cur_mask [$];
  logic [7:0] cur_subj [$];

  function automatic logic [7:0] upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? {c[7:6], 1'b0, c[4:0]} : c;
  endfunction

  // an active star also activates the position after it; runs low to high
  // so a chain of stars opens in one pass
  function automatic void open_stars();
    for (int i = 0; i < pat_len; i++) begin
      if (live[i] && pat_mem[i] == STAR_CHAR) begin
        live[i+1] = 1'b1;
      end
    end
  endfunction

  function automatic void tracker_reset();
    pat_len = 0;
    pat_dropped = 1'b0;
    live = '0;
    live[0] = 1'b1;
    for (int i = 0; i < MASK_LEN; i++) begin
      pat_mem[i] = 8'h00;
    end
  endfunction

  // update the tracker for one accepted request, queue a verdict if any
  function automatic void predict_req(input req_type_t kind, input logic [7:0] b);
    logic [MASK_LEN:0] nxt;
    gwm_res_t          v;
    nxt = '0;
    case (kind)
      REQ_CLEAR: begin
        pat_len = 0;
        pat_dropped = 1'b0;
        live = '0;
        live[0] = 1'b1;
      end
      REQ_MASK: begin
        if (b != 8'h00) begin
          if (pat_len < MASK_LEN) begin
            pat_mem[pat_len] = b;
            pat_len++;
          end else begin
            pat_dropped = 1'b1;
          end
          live = '0;
          live[0] = 1'b1;
        end
      end
      REQ_SUBJ: begin
        if (b != 8'h00) begin
          open_stars();
          for (int i = 0; i < pat_len; i++) begin
            if (live[i]) begin
              if (pat_mem[i] == STAR_CHAR) begin
                nxt[i] = 1'b1;
              end else if (pat_mem[i] == ANY_CHAR ||
                           upper(pat_mem[i]) == upper(b)) begin
                nxt[i+1] = 1'b1;
              end
            end
          end
          live = nxt;
        end
      end
      default: begin
        open_stars();
        v.matched = live[pat_len];
        v.mask_overflow = pat_dropped;
        pending_verdicts.push_back(v);
        live = '0;
        live[0] = 1'b1;
      end
    endcase
  endfunction

  function automatic void check_result(input logic [7:0] got);
    gwm_res_t exp_v;
    if (pending_verdicts.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("unexpected result at %0t: tdata=%02h", $realtime, got);
      end
    end else begin
      exp_v = pending_verdicts.pop_front();
      if (got[0] !== exp_v.matched || got[1] !== exp_v.mask_overflow ||
          got[7:2] !== 6'b0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display({"result mismatch at %0t: exp matched=%0b overflow=%0b pad=00, ",
                    "got matched=%0b overflow=%0b pad=%02h"},
                   $realtime, exp_v.matched, exp_v.mask_overflow, got[0], got[1], got[7:2]);
        end
      end
    end
  endfunction

  // results are checked before the same edge's request is predicted; a
  // verdict never leaves in the cycle its request enters
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        check_result(out_tdata);
      end
      if (in_tvalid && in_tready) begin
        predict_req(req_type_t'(in_tuser), in_tdata);
      end
    end
  end

  // receiver: random stalls, or a full hold-off while rx_hold is up
  always @(posedge clk) begin
    out_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // offer one request and wait for its handshake; valid stays high into the
  // next request unless the sender decides to idle first
  task automatic send_req(input req_type_t kind, input logic [7:0] b);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tuser  <= 2'($urandom_range(3));
      in_tdata  <= 8'($urandom);
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    if (!((kind == REQ_MASK || kind == REQ_SUBJ) && b == 8'h00)) begin
      live_reqs++;
    end
  endtask

  // mask bytes: mostly stars, any-marks and a tiny alphabet in mixed case,
  // so random subjects match often
  function automatic logic [7:0] pick_mask_char();
    int unsigned roll;
    logic [7:0]  c;
    roll = $urandom_range(99);
    if (roll < 25) begin
      c = STAR_CHAR;
    end else if (roll < 40) begin
      c = ANY_CHAR;
    end else if (roll < 85) begin
      c = 8'h41 + 8'($urandom_range(2));
      if ($urandom_range(1)) c = c | 8'h20;
    end else begin
      c = 8'($urandom_range(255, 1));
    end
    return c;
  endfunction

  function automatic logic [7:0] pick_filler();
    int unsigned roll;
    roll = $urandom_range(4);
    if (roll == 3) return STAR_CHAR;
    if (roll == 4) return ANY_CHAR;
    return 8'h61 + 8'(roll);
  endfunction

  function automatic void make_mask(input int unsigned len);
    cur_mask.delete();
    repeat (len) cur_mask.push_back(pick_mask_char());
  endfunction

  // subject shaped after the mask, then sometimes damaged
  function automatic void make_subject();
    int unsigned n;
    logic [7:0]  c;
    cur_subj.delete();
    foreach (cur_mask[i]) begin
      c = cur_mask[i];
      if (c == STAR_CHAR) begin
        n = $urandom_range(3);
        repeat (n) cur_subj.push_back(pick_filler());
      end else if (c == ANY_CHAR) begin
        cur_subj.push_back(8'($urandom_range(255, 1)));
      end else begin
        if (upper(c) != c || (c >= 8'h41 && c <= 8'h5A)) begin
          if ($urandom_range(1)) c = c ^ 8'h20;
        end
        cur_subj.push_back(c);
      end
    end
    case ($urandom_range(7))
      0: if (cur_subj.size() > 0) cur_subj[$urandom_range(cur_subj.size() - 1)] = pick_filler();
      1: if (cur_subj.size() > 0) cur_subj.delete($urandom_range(cur_subj.size() - 1));
      2: cur_subj.insert($urandom_range(cur_subj.size()), 8'($urandom_range(255, 1)));
      default: ;
    endcase
  endfunction

  task automatic send_mask();
    foreach (cur_mask[i]) send_req(REQ_MASK, cur_mask[i]);
  endtask

  // subject bytes with the odd ignored zero byte, closed by an end request
  task automatic send_subject();
    foreach (cur_subj[i]) begin
      if ($urandom_range(19) == 0) send_req(REQ_SUBJ, 8'h00);
      send_req(REQ_SUBJ, cur_subj[i]);
    end
    send_req(REQ_END, 8'($urandom));
  endtask

  // empty mask against empty and non-empty subjects
  task automatic test_empty_mask();
    send_req(REQ_CLEAR, 8'hFF);
    send_req(REQ_END, 8'h00);
    send_req(REQ_SUBJ, "a");
    send_req(REQ_END, 8'hFF);
  endtask

  // star, any-mark, case folding, ignored zero bytes, literal star in subject
  task automatic test_wildcards_and_case();
    send_req(REQ_MASK, "a");
    send_req(REQ_MASK, 8'h00);
    send_req(REQ_MASK, STAR_CHAR);
    send_req(REQ_MASK, ANY_CHAR);
    send_req(REQ_MASK, "Z");
    send_req(REQ_SUBJ, "A");
    send_req(REQ_SUBJ, 8'h00);
    send_req(REQ_SUBJ, STAR_CHAR);
    send_req(REQ_SUBJ, "z");
    send_req(REQ_END, 8'h00);
  endtask

  // a mask append in the middle of a subject forgets the bytes before it
  task automatic test_mask_edit_restart();
    send_req(REQ_SUBJ, "A");
    send_req(REQ_MASK, "z");
    send_req(REQ_SUBJ, "a");
    send_req(REQ_SUBJ, "q");
    send_req(REQ_SUBJ, "Z");
    send_req(REQ_SUBJ, "z");
    send_req(REQ_END, 8'h00);
    send_req(REQ_SUBJ, 8'hFF);
    send_req(REQ_END, 8'h00);
  endtask

  // exactly full mask, then dropped bytes, then a clear of the flag
  task automatic test_mask_overflow();
    send_req(REQ_CLEAR, 8'h00);
    make_mask(MASK_LEN);
    send_mask();
    make_subject();
    send_subject();
    repeat (3) send_req(REQ_MASK, pick_mask_char());
    make_subject();
    send_subject();
    make_subject();
    send_subject();
    send_req(REQ_CLEAR, 8'h00);
    send_req(REQ_END, 8'h00);
  endtask

  // receiver holds off while end requests keep coming, so the result
  // buffer fills and in_tready must fall
  task automatic test_output_backpressure();
    send_req(REQ_CLEAR, 8'h00);
    make_mask(3);
    send_mask();
    fork
      begin
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
      end
      begin
        repeat (16) begin
          make_subject();
          send_subject();
        end
      end
    join
  endtask

  // mostly well-formed mask/subject sequences, some raw noise requests
  task automatic test_random_traffic(input int unsigned n_reqs, input int unsigned tx_pct,
                                     input int unsigned rx_pct);
    int unsigned stop_at;
    int unsigned len;
    stop_at = live_reqs + n_reqs;
    tx_idle_pct = tx_pct;
    rx_stall_pct <= rx_pct;
    while (live_reqs < stop_at) begin
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(9) != 0) send_req(REQ_CLEAR, 8'($urandom));
        len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8);
        make_mask(len);
        send_mask();
        repeat ($urandom_range(4, 1)) begin
          make_subject();
          send_subject();
        end
      end else begin
        repeat ($urandom_range(6, 1)) begin
          send_req(req_type_t'($urandom_range(3)),
                   ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    tracker_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_mask();
    test_wildcards_and_case();
    test_mask_edit_restart();
    test_mask_overflow();
    test_output_backpressure();
    test_random_traffic(230, 0, 0);
    test_random_traffic(230, 88, 0);
    test_random_traffic(230, 0, 88);
    test_random_traffic(230, 37, 37);

    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    // then wait on so that any stray result is caught
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #(12 * 1000000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
